// ===== sv/bdef_pkg.sv =====
package bdef_pkg;

	// Number of pushbuttons; fixed by the width of the level fields.
	localparam int NUM_BUTTONS = 5;
	localparam int IDX_W = 3;
	localparam int SETTLE_W = 8;
	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd10;

	// APB register map.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_SETTLE = 1'b0;

	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_RD_PRESSED = 2'd1,
		OP_RD_RISING  = 2'd2,
		OP_RD_FALLING = 2'd3
	} op_t;

	// Per-lane commands from the request decoder.
	typedef struct packed {
		logic tick;
		logic clr_pressed;
		logic clr_rising;
		logic clr_falling;
	} lane_ctrl_t;

	// Per-lane state seen by the merging stage.
	typedef struct packed {
		logic level_next;
		logic pressed;
		logic rising;
		logic falling;
	} lane_stat_t;

	typedef struct packed {
		logic                   flag_value;
		logic [NUM_BUTTONS-1:0] debounced_levels;
	} res_t;

endpackage

// ===== sv/bdef_if.sv =====
interface bdef_req_if import bdef_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       operation;
	logic [4:0]       raw_levels;
	logic [IDX_W-1:0] button_index;

	modport source (output valid, operation, raw_levels, button_index, input ready);
	modport sink (input valid, operation, raw_levels, button_index, output ready);
endinterface

interface bdef_res_if import bdef_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       flag_value;
	logic [4:0] debounced_levels;

	modport source (output valid, flag_value, debounced_levels, input ready);
	modport sink (input valid, flag_value, debounced_levels, output ready);
endinterface

// ===== sv/bdef_lane.sv =====
module bdef_lane import bdef_pkg::*; #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lane_ctrl_t          ctrl,
	input  logic                raw,
	input  logic [SETTLE_W-1:0] settle_count,
	output lane_stat_t          stat
);

	localparam int CMP_W = (COUNT_WIDTH > SETTLE_W) ? COUNT_WIDTH : SETTLE_W;

	logic                   level_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   pressed_q;
	logic                   rising_q;
	logic                   falling_q;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic                   differ;
	logic                   hit;
	logic                   flip;

	// Compare the incremented count against the setting at a common width, so a
	// setting beyond the counter range never matches.
	assign differ  = raw != level_q;
	assign cnt_inc = cnt_q + COUNT_WIDTH'(1);
	assign hit     = CMP_W'(cnt_inc) == CMP_W'(settle_count);
	assign flip    = ctrl.tick && differ && hit;

	assign stat.level_next = flip ? raw : level_q;
	assign stat.pressed    = pressed_q;
	assign stat.rising     = rising_q;
	assign stat.falling    = falling_q;

	// Settle counter, debounced level and sticky flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= 1'b0;
			cnt_q     <= '0;
			pressed_q <= 1'b0;
			rising_q  <= 1'b0;
			falling_q <= 1'b0;
		end else begin
			if (ctrl.tick) begin
				if (raw) begin
					pressed_q <= 1'b1;
				end
				if (!differ) begin
					cnt_q <= '0;
				end else if (hit) begin
					cnt_q   <= '0;
					level_q <= raw;
					if (raw) begin
						rising_q <= 1'b1;
					end else begin
						falling_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_inc;
				end
			end
			if (ctrl.clr_pressed) begin
				pressed_q <= 1'b0;
			end
			if (ctrl.clr_rising) begin
				rising_q <= 1'b0;
			end
			if (ctrl.clr_falling) begin
				falling_q <= 1'b0;
			end
		end
	end

	// A cleared flag reads low on the next cycle.
	a_clr_rising: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clr_rising |=> !rising_q)
		else $error("rising flag survived a clear");

	// A query leaves the counter and the debounced level untouched.
	a_query_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.tick |=> ($stable(cnt_q) && $stable(level_q)))
		else $error("counter or level changed without a tick");

endmodule

// ===== sv/bdef_merge.sv =====
module bdef_merge import bdef_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  op_t              op,
	input  logic [IDX_W-1:0] button_index,
	input  lane_stat_t       stat [NUM_BUTTONS],
	output logic             space,
	bdef_res_if.source       result
);

	res_t res_new;
	res_t main_q;
	res_t skid_q;
	logic main_valid_q;
	logic skid_valid_q;
	logic idx_ok;
	logic pop;

	// Gather the lanes' levels and pick the queried flag.
	assign idx_ok = button_index < IDX_W'(NUM_BUTTONS);

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			res_new.debounced_levels[i] = stat[i].level_next;
		end
		res_new.flag_value = 1'b0;
		if (idx_ok) begin
			case (op)
				OP_RD_PRESSED: res_new.flag_value = stat[button_index].pressed;
				OP_RD_RISING:  res_new.flag_value = stat[button_index].rising;
				OP_RD_FALLING: res_new.flag_value = stat[button_index].falling;
				default:       res_new.flag_value = 1'b0;
			endcase
		end
	end

	// Two-entry output buffer: a new request is taken while a result waits.
	assign pop   = main_valid_q && result.ready;
	assign space = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= res_new;
			end else begin
				main_q <= res_new;
			end
		end
	end

	assign result.valid            = main_valid_q;
	assign result.flag_value       = main_q.flag_value;
	assign result.debounced_levels = main_q.debounced_levels;

	// The spare slot only fills behind a waiting result.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("spare slot holds a result with the main slot empty");

	// No request is taken into a full buffer.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("request accepted while output buffer full");

endmodule

// ===== sv/button_debounce_edge_flags_core.sv =====
// A result is registered in the output buffer when its request is accepted.
// One request per cycle while the output buffer has space; every button has its own counter lane and
// a two-entry output buffer takes one more request while a result waits.
// Reset (arst_n, asynchronous, active low) clears levels, counters, flags and
// buffer; settle_count returns to 10.
module button_debounce_edge_flags_core import bdef_pkg::*; #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	bdef_req_if.sink           request,
	bdef_res_if.source         result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic                settle_q;
	logic [SETTLE_W-1:0] settle_count_q;
	logic                accept;
	logic                space;
	logic                idx_ok;
	op_t                 op;
	lane_ctrl_t          ctrl [NUM_BUTTONS];
	lane_stat_t          stat [NUM_BUTTONS];

	// Configuration register.
	assign pready   = 1'b1;
	assign settle_q = paddr[2] == REG_SETTLE;
	assign prdata   = settle_q ? PDATA_W'(settle_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_count_q <= SETTLE_RESET;
		end else if (psel && penable && pwrite && pready && settle_q) begin
			settle_count_q <= pwdata[SETTLE_W-1:0];
		end
	end

	// Request decode into per-lane commands.
	assign request.ready = space;
	assign accept        = request.valid && space;
	assign op            = op_t'(request.operation);
	assign idx_ok        = request.button_index < IDX_W'(NUM_BUTTONS);

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			ctrl[i].tick        = accept && (op == OP_TICK);
			ctrl[i].clr_pressed = accept && idx_ok && (op == OP_RD_PRESSED)
				&& (request.button_index == IDX_W'(i));
			ctrl[i].clr_rising  = accept && idx_ok && (op == OP_RD_RISING)
				&& (request.button_index == IDX_W'(i));
			ctrl[i].clr_falling = accept && idx_ok && (op == OP_RD_FALLING)
				&& (request.button_index == IDX_W'(i));
		end
	end

	// One debounce lane per button.
	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		bdef_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl[g]),
			.raw          (request.raw_levels[g]),
			.settle_count (settle_count_q),
			.stat         (stat[g])
		);
	end

	// Merge the lanes into one result and buffer it.
	bdef_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (accept),
		.op           (op),
		.button_index (request.button_index),
		.stat         (stat),
		.space        (space),
		.result       (result)
	);

endmodule

// ===== tb/bdef_checker.sv =====
module bdef_checker import bdef_pkg::*; #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	bdef_req_if                request,
	bdef_res_if                result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	output int                 error_count,
	output int                 outstanding,
	output int                 tick_count,
	output int                 query_count,
	output int                 flip_count,
	output int                 hit_count
);

	// Shadow copy of the debouncer state and its one register.
	logic [SETTLE_W-1:0]    settle;
	logic [NUM_BUTTONS-1:0] level;
	logic [NUM_BUTTONS-1:0] pressed;
	logic [NUM_BUTTONS-1:0] rising;
	logic [NUM_BUTTONS-1:0] falling;
	logic [COUNT_WIDTH-1:0] run_len [NUM_BUTTONS];

	// Flag and level words owed by the block, oldest first.
	res_t due_outputs [$];

	initial begin
		error_count = 0;
		tick_count  = 0;
		query_count = 0;
		flip_count  = 0;
		hit_count   = 0;
		outstanding = 0;
	end

	// Prints the first few mismatches and counts all of them.
	task automatic report_mismatch(input string msg);
		if (error_count < 20) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
		error_count++;
	endtask

	// Applies one request to the shadow state and works out the word it returns.
	task automatic step_buttons(input op_t op, input logic [4:0] raw,
			input logic [IDX_W-1:0] idx, output res_t res);
		logic flag;
		flag = 1'b0;
		if (op == OP_TICK) begin
			tick_count++;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				// The pressed flag follows the raw level, not the debounced one.
				if (raw[b]) begin
					pressed[b] = 1'b1;
				end
				if (raw[b] != level[b]) begin
					run_len[b] = run_len[b] + 1'b1;
					if (run_len[b] == settle) begin
						run_len[b] = '0;
						level[b]   = raw[b];
						flip_count++;
						if (raw[b]) begin
							rising[b] = 1'b1;
						end else begin
							falling[b] = 1'b1;
						end
					end
				end else begin
					run_len[b] = '0;
				end
			end
		end else begin
			query_count++;
			// An index past the last button reads zero and clears nothing.
			if (idx < NUM_BUTTONS) begin
				case (op)
					OP_RD_PRESSED: begin
						flag = pressed[idx];
						pressed[idx] = 1'b0;
					end
					OP_RD_RISING: begin
						flag = rising[idx];
						rising[idx] = 1'b0;
					end
					default: begin
						flag = falling[idx];
						falling[idx] = 1'b0;
					end
				endcase
			end
			if (flag) begin
				hit_count++;
			end
		end
		res.flag_value       = flag;
		res.debounced_levels = level;
	endtask

	// Watches both channels and the register port on every rising edge.
	always @(posedge clk or negedge arst_n) begin
		res_t fresh;
		res_t oldest;
		if (!arst_n) begin
			settle  = SETTLE_RESET;
			level   = '0;
			pressed = '0;
			rising  = '0;
			falling = '0;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				run_len[b] = '0;
			end
			due_outputs.delete();
		end else begin
			if (request.valid && request.ready) begin
				step_buttons(op_t'(request.operation), request.raw_levels,
					request.button_index, fresh);
				due_outputs.push_back(fresh);
			end
			if (result.valid && result.ready) begin
				if (due_outputs.size() == 0) begin
					report_mismatch("result with no request waiting");
				end else begin
					oldest = due_outputs.pop_front();
					if (result.flag_value !== oldest.flag_value) begin
						report_mismatch($sformatf("flag_value got %0b want %0b",
							result.flag_value, oldest.flag_value));
					end
					if (result.debounced_levels !== oldest.debounced_levels) begin
						report_mismatch($sformatf("debounced_levels got %05b want %05b",
							result.debounced_levels, oldest.debounced_levels));
					end
				end
			end
			// Register writes land on the access edge; other indexes are ignored.
			if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_SETTLE) begin
				if (pwrite) begin
					settle = pwdata[SETTLE_W-1:0];
				end else if (prdata[SETTLE_W-1:0] !== settle) begin
					report_mismatch($sformatf("settle_count read %0d want %0d",
						prdata[SETTLE_W-1:0], settle));
				end
			end
		end
		outstanding <= due_outputs.size();
	end

endmodule

// ===== tb/button_debounce_edge_flags_core_tb.sv =====
module button_debounce_edge_flags_core_tb;
	import bdef_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam logic [PADDR_W-1:0] ADDR_SETTLE = {REG_SETTLE, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_SPARE = 3'd4;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int error_count;
	int outstanding;
	int tick_count;
	int query_count;
	int flip_count;
	int hit_count;
	int settle_changes;
	int cur_settle;

	// Knobs shared by the sending and receiving processes.
	bit sender_quiet;
	bit receiver_quiet;
	bit stall_burst;

	bdef_req_if req_ch ();
	bdef_res_if res_ch ();

	button_debounce_edge_flags_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bdef_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (req_ch),
		.result      (res_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.error_count (error_count),
		.outstanding (outstanding),
		.tick_count  (tick_count),
		.query_count (query_count),
		.flip_count  (flip_count),
		.hit_count   (hit_count)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Mostly no pause, sometimes a short one, now and then a long one.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 20);
	endfunction

	// Offers one request after a random pause and waits until it is taken.
	task automatic send_item(input op_t op, input logic [4:0] raw,
			input logic [IDX_W-1:0] idx);
		int gap;
		gap = sender_quiet ? 0 : idle_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.operation    <= op;
		req_ch.raw_levels   <= raw;
		req_ch.button_index <= idx;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// A flag query, mostly for a real button and sometimes past the last one.
	task automatic send_query();
		logic [IDX_W-1:0] idx;
		idx = ($urandom_range(0, 6) == 0) ? IDX_W'($urandom_range(NUM_BUTTONS, 7))
			: IDX_W'($urandom_range(0, NUM_BUTTONS - 1));
		send_item(op_t'(2'($urandom_range(OP_RD_PRESSED, OP_RD_FALLING))),
			5'($urandom_range(0, 31)), idx);
	endtask

	// One APB transfer: setup cycle, access cycle, then a rest with the bus idle.
	task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Stops sending and waits until every owed result has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes settle_count with junk in the upper bits, then reads it back.
	task automatic set_settle(input int value);
		logic [PDATA_W-1:0] data;
		drain();
		data = $urandom();
		data[SETTLE_W-1:0] = SETTLE_W'(value);
		apb_access(1'b1, ADDR_SETTLE, data);
		apb_access(1'b0, ADDR_SETTLE, '0);
		cur_settle = value;
		settle_changes++;
	endtask

	// Holds one raw pattern for a number of ticks with the odd query between.
	task automatic hold_level(input logic [4:0] raw, input int n_ticks);
		int ticks;
		ticks = 0;
		while (ticks < n_ticks) begin
			if ($urandom_range(0, 7) == 0) begin
				send_query();
			end else begin
				send_item(OP_TICK, raw, IDX_W'($urandom_range(0, 7)));
				ticks++;
			end
		end
	endtask

	// Button presses that settle for a random time, with bounce, noise and queries.
	task automatic run_random(input int n_items);
		int sent;
		int hold;
		int roll;
		logic [4:0] target;
		logic [4:0] raw;
		sent = 0;
		while (sent < n_items) begin
			target = 5'($urandom_range(0, 31));
			hold   = $urandom_range(1, cur_settle + 3);
			for (int k = 0; k < hold && sent < n_items; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 20) begin
					send_query();
				end else if (roll < 28) begin
					send_item(OP_TICK, 5'($urandom_range(0, 31)),
						IDX_W'($urandom_range(0, 7)));
				end else begin
					raw = target;
					if ($urandom_range(0, 7) == 0) begin
						raw = raw ^ 5'($urandom_range(1, 31));
					end
					send_item(OP_TICK, raw, IDX_W'($urandom_range(0, 7)));
				end
				sent++;
			end
		end
	endtask

	// Result side: random stalls, quiet stretches and one long hold-off.
	initial begin
		int gap;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (stall_burst) begin
				stall_burst = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (receiver_quiet) begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				gap = idle_len();
				if (gap > 0) begin
					res_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// Request side and verdict.
	initial begin
		req_ch.valid        = 1'b0;
		req_ch.operation    = OP_TICK;
		req_ch.raw_levels   = '0;
		req_ch.button_index = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		sender_quiet   = 1'b0;
		receiver_quiet = 1'b0;
		stall_burst    = 1'b0;
		settle_changes = 0;
		cur_settle     = int'(SETTLE_RESET);
		arst_n         = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset value must read back before anything is written.
		apb_access(1'b0, ADDR_SETTLE, '0);

		// Directed part with a one-tick settle so every change lands at once.
		set_settle(1);
		send_item(OP_TICK, 5'b11111, 3'd0);
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			send_item(OP_RD_RISING, 5'b00000, IDX_W'(b));
		end
		send_item(OP_RD_RISING, 5'b11111, 3'd0);
		send_item(OP_RD_PRESSED, 5'b00000, 3'd4);
		send_item(OP_RD_PRESSED, 5'b11111, 3'd5);
		send_item(OP_RD_FALLING, 5'b00000, 3'd7);
		send_item(OP_TICK, 5'b00000, 3'd7);
		send_item(OP_RD_FALLING, 5'b01010, 3'd3);
		send_item(OP_RD_FALLING, 5'b10101, 3'd6);
		send_item(OP_TICK, 5'b10101, 3'd2);
		send_item(OP_TICK, 5'b01010, 3'd5);
		send_item(OP_RD_RISING, 5'b00000, 3'd1);
		send_item(OP_RD_FALLING, 5'b00000, 3'd0);
		send_item(OP_RD_PRESSED, 5'b00000, 3'd0);
		send_item(OP_RD_PRESSED, 5'b00000, 3'd0);

		// A write to the spare register index must leave settle_count alone.
		drain();
		apb_access(1'b1, ADDR_SPARE, $urandom());
		apb_access(1'b0, ADDR_SETTLE, '0);
		apb_access(1'b0, ADDR_SPARE, '0);

		// Short settle, with one long stall on the result side under full load.
		set_settle(3);
		run_random(150);
		stall_burst  = 1'b1;
		sender_quiet = 1'b1;
		run_random(40);
		sender_quiet = 1'b0;
		run_random(110);
		hold_level(5'b00000, 6);

		// Longest settle: every button rises on the 255th tick of the hold.
		set_settle(255);
		hold_level(5'b11111, 258);

		// Zero settle: the counter wraps round before the buttons fall.
		set_settle(0);
		hold_level(5'b00000, 258);

		// Mid-range settles, including a stretch with no pauses on either side.
		set_settle($urandom_range(2, 12));
		run_random(220);
		set_settle($urandom_range(2, 12));
		sender_quiet   = 1'b1;
		receiver_quiet = 1'b1;
		run_random(150);
		sender_quiet   = 1'b0;
		receiver_quiet = 1'b0;
		run_random(100);

		set_settle(1);
		run_random(200);
		drain();

		$display("Run covered %0d sample ticks and %0d flag queries over %0d settle settings.",
			tick_count, query_count, settle_changes);
		$display("Saw %0d debounced level changes and %0d set flags read back.",
			flip_count, hit_count);
		if (error_count == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
